// File: rtl/gain_clip_overload_power_meter_core_assert.svh
// Assertion macros used by the gain, clip and power meter core.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef GAIN_CLIP_OVERLOAD_POWER_METER_CORE_ASSERT_SVH
`define GAIN_CLIP_OVERLOAD_POWER_METER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCOP_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCOP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gcop_pkg.sv
// Constants and types of the gain, clip and power meter block.
// No dependencies; every other file of the block but the assertion header uses it.
package gcop_pkg;

  localparam int CHANNELS     = 8;
  localparam int SAMPLE_WIDTH = 16;

  localparam int CH_W     = 3;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;
  localparam int SMOOTH_W  = 16;
  localparam int LIM_W     = SAMPLE_WIDTH - 1;
  localparam int POWER_W   = 2 * SAMPLE_WIDTH - 2;

  // Gained sample before clamping.
  localparam int Y_W = SAMPLE_WIDTH + GAIN_W - GAIN_FRAC;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = (SAMPLE_WIDTH > GAIN_W + 1) ? SAMPLE_WIDTH : GAIN_W + 1;
  localparam int MUL_B_W = (POWER_W + 1 > SMOOTH_W + 1) ? POWER_W + 1 : SMOOTH_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (LIM_W > GAIN_W) ? LIM_W : GAIN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 2'd2;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd4096;
  localparam logic [LIM_W-1:0]    CLIP_RESET   = {LIM_W{1'b1}};
  localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 16'd62259;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [LIM_W-1:0]    clip_limit;
    logic [SMOOTH_W-1:0] smoothing;
  } cfg_t;

endpackage

// File: rtl/gcop_if.sv
// Valid/ready channel interfaces of the gain, clip and power meter block.
// Depends on gcop_pkg for field widths.
interface gcop_sample_if;
  logic                                    valid;
  logic                                    ready;
  logic [gcop_pkg::CH_W-1:0]               channel;
  logic signed [gcop_pkg::SAMPLE_WIDTH-1:0] sample_in;
  logic                                    clear_overload;
  logic                                    block_end;

  modport source (output valid, channel, sample_in, clear_overload, block_end,
                  input ready);
  modport sink (input valid, channel, sample_in, clear_overload, block_end,
                output ready);
endinterface

interface gcop_result_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [gcop_pkg::SAMPLE_WIDTH-1:0] sample_out;
  logic [gcop_pkg::CH_W-1:0]               channel_out;
  logic [gcop_pkg::POWER_W-1:0]            power_out;
  logic                                    overload_out;
  logic                                    block_end_out;

  modport source (output valid, sample_out, channel_out, power_out, overload_out,
                  block_end_out, input ready);
  modport sink (input valid, sample_out, channel_out, power_out, overload_out,
                block_end_out, output ready);
endinterface

interface gcop_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [gcop_pkg::CFG_IDX_W-1:0]     index;
  logic [gcop_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/gain_clip_overload_power_meter_core.sv
// Gain, clipper and per-channel power meter. From acceptance until its result
// is loaded into the output register, each sample beat passes through the
// accept step, then gain multiply, clamp, square, difference, smoothing
// multiply and power update. All three products go through one registered
// multiplier; a new sample is accepted only while the sequencer is idle, but a
// finished result may wait in the output register while the next sample is
// taken. Powers and overload flags clear at reset.
// Depends on gcop_pkg, the channel interfaces, gcop_cfg and gcop_mul.
`include "gain_clip_overload_power_meter_core_assert.svh"

module gain_clip_overload_power_meter_core (
  input  logic         clk,
  input  logic         rst,
  gcop_sample_if.sink  sample_ch,
  gcop_result_if.source result_ch,
  gcop_cfg_if.sink     cfg_ch
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GAIN   = 3'd1;
  localparam logic [2:0] S_CLIP   = 3'd2;
  localparam logic [2:0] S_SQ     = 3'd3;
  localparam logic [2:0] S_DIFF   = 3'd4;
  localparam logic [2:0] S_SMOOTH = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam int SW = gcop_pkg::SAMPLE_WIDTH;
  localparam int PW = gcop_pkg::POWER_W;
  localparam int YW = gcop_pkg::Y_W;

  gcop_pkg::cfg_t cfg;

  logic [2:0] state;

  logic [gcop_pkg::CH_W-1:0]     ch_r;
  logic signed [SW-1:0]          s_r;
  logic                          clr_r;
  logic                          blk_r;

  logic signed [SW-1:0]          y_r;
  logic [SW-2:0]                 mag_r;
  logic                          flag_r;
  logic [PW-1:0]                 p_r;
  logic [PW-1:0]                 y2_r;
  logic signed [PW:0]            d_r;

  logic [PW-1:0]                 power [gcop_pkg::CHANNELS];
  logic [gcop_pkg::CHANNELS-1:0] ovl;

  logic                          res_valid;
  logic signed [SW-1:0]          res_sample;
  logic [gcop_pkg::CH_W-1:0]     res_channel;
  logic [PW-1:0]                 res_power;
  logic                          res_flag;
  logic                          res_blk;

  logic signed [gcop_pkg::MUL_A_W-1:0] op_a;
  logic signed [gcop_pkg::MUL_B_W-1:0] op_b;
  logic signed [gcop_pkg::MUL_P_W-1:0] prod;

  logic                            ch_valid;
  logic [gcop_pkg::CH_IDX_W-1:0]   chan_idx;
  logic signed [YW-1:0]            y_full;
  logic signed [YW-1:0]            lim_pos;
  logic signed [YW-1:0]            y_clip;
  logic                            clip_hit;
  logic [SW-2:0]                   mag;
  logic signed [PW:0]              smooth_term;
  logic [PW-1:0]                   newp;
  logic                            flag_new;
  logic                            out_free;
  logic signed [SW-1:0]            lim_s;

  gcop_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  gcop_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign ch_valid = int'(ch_r) < gcop_pkg::CHANNELS;
  assign chan_idx = gcop_pkg::CH_IDX_W'(ch_r);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      S_GAIN: begin
        op_a = gcop_pkg::MUL_A_W'(s_r);
        op_b = gcop_pkg::MUL_B_W'({1'b0, cfg.gain});
      end
      S_SQ: begin
        op_a = gcop_pkg::MUL_A_W'({1'b0, mag_r});
        op_b = gcop_pkg::MUL_B_W'({1'b0, mag_r});
      end
      // The smoothing operands stay applied while the result waits, so the
      // product holds until the power is written.
      S_SMOOTH, S_OUT: begin
        op_a = gcop_pkg::MUL_A_W'({1'b0, cfg.smoothing});
        op_b = gcop_pkg::MUL_B_W'(d_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Taking the high bits of the product floors toward minus infinity.
  assign y_full  = prod[gcop_pkg::GAIN_FRAC+YW-1:gcop_pkg::GAIN_FRAC];
  assign lim_pos = {{(YW-gcop_pkg::LIM_W){1'b0}}, cfg.clip_limit};

  always_comb begin
    if (y_full > lim_pos) begin
      y_clip   = lim_pos;
      clip_hit = 1'b1;
    end else if (y_full < -lim_pos) begin
      y_clip   = -lim_pos;
      clip_hit = 1'b1;
    end else begin
      y_clip   = y_full;
      clip_hit = 1'b0;
    end
  end

  assign mag      = y_clip[YW-1] ? (SW-1)'(-y_clip) : (SW-1)'(y_clip);
  assign flag_new = ch_valid & ((ovl[chan_idx] & ~clr_r) | clip_hit);

  // New power is y2 plus the floored smoothing share of (p - y2).
  assign smooth_term = prod[gcop_pkg::SMOOTH_W+PW:gcop_pkg::SMOOTH_W];
  assign newp        = PW'(y2_r + PW'(smooth_term));

  assign out_free        = !res_valid || result_ch.ready;
  assign sample_ch.ready = (state == S_IDLE);

  assign result_ch.valid         = res_valid;
  assign result_ch.sample_out    = res_sample;
  assign result_ch.channel_out   = res_channel;
  assign result_ch.power_out     = res_power;
  assign result_ch.overload_out  = res_flag;
  assign result_ch.block_end_out = res_blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      ovl       <= '0;
      for (int i = 0; i < gcop_pkg::CHANNELS; i++) begin
        power[i] <= '0;
      end
    end else begin
      // A result loaded this cycle takes the place of one that leaves.
      if ((state == S_OUT) && out_free) begin
        res_valid <= 1'b1;
      end else if (result_ch.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_ch.valid) begin
            ch_r  <= sample_ch.channel;
            s_r   <= sample_ch.sample_in;
            clr_r <= sample_ch.clear_overload;
            blk_r <= sample_ch.block_end;
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          state <= S_CLIP;
        end
        S_CLIP: begin
          y_r    <= SW'(y_clip);
          mag_r  <= mag;
          flag_r <= flag_new;
          p_r    <= power[chan_idx];
          if (ch_valid) begin
            ovl[chan_idx] <= flag_new;
          end
          state <= S_SQ;
        end
        S_SQ: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          y2_r  <= prod[PW-1:0];
          d_r   <= $signed({1'b0, p_r}) - $signed({1'b0, prod[PW-1:0]});
          state <= S_SMOOTH;
        end
        S_SMOOTH: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (ch_valid) begin
              power[chan_idx] <= newp;
            end
            res_sample  <= y_r;
            res_channel <= ch_r;
            res_power   <= ch_valid ? newp : '0;
            res_flag    <= flag_r;
            res_blk     <= blk_r;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign lim_s = {1'b0, cfg.clip_limit};

  `GCOP_ASSERT_SAME(a_out_within_limit, result_ch.valid,
    (result_ch.sample_out <= lim_s) && (result_ch.sample_out >= -lim_s),
    "result sample outside the clip limit")
  `GCOP_ASSERT_NEXT(a_clip_sets_flag, (state == S_CLIP) && ch_valid && clip_hit,
    ovl[chan_idx], "clamp did not set the overload flag")
  `GCOP_ASSERT_SAME(a_power_between, (state == S_OUT) && ch_valid,
    ((newp >= y2_r) && (newp <= p_r)) || ((newp <= y2_r) && (newp >= p_r)),
    "smoothed power outside old power and squared sample")
  `GCOP_ASSERT_SAME(a_bad_channel_quiet,
    result_ch.valid && (int'(result_ch.channel_out) >= gcop_pkg::CHANNELS),
    (result_ch.power_out == '0) && !result_ch.overload_out,
    "unknown channel reported power or overload")

endmodule

// File: rtl/gcop_cfg.sv
// Configuration registers: gain, clip limit and smoothing factor.
// Depends on gcop_pkg and the gcop_cfg_if interface.
module gcop_cfg (
  input  logic             clk,
  input  logic             rst,
  gcop_cfg_if.sink         cfg_ch,
  output gcop_pkg::cfg_t   cfg
);

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain       <= gcop_pkg::GAIN_RESET;
      cfg.clip_limit <= gcop_pkg::CLIP_RESET;
      cfg.smoothing  <= gcop_pkg::SMOOTH_RESET;
    end else if (cfg_ch.valid) begin
      // Writes to an unused index are dropped.
      case (cfg_ch.index)
        gcop_pkg::CFG_GAIN:   cfg.gain       <= cfg_ch.data[gcop_pkg::GAIN_W-1:0];
        gcop_pkg::CFG_CLIP:   cfg.clip_limit <= cfg_ch.data[gcop_pkg::LIM_W-1:0];
        gcop_pkg::CFG_SMOOTH: cfg.smoothing  <= cfg_ch.data[gcop_pkg::SMOOTH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/gcop_mul.sv
// Shared signed multiplier with a registered product.
// Depends on gcop_pkg for operand widths.
module gcop_mul (
  input  logic                                clk,
  input  logic signed [gcop_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [gcop_pkg::MUL_B_W-1:0] op_b,
  output logic signed [gcop_pkg::MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// File: verif/power_meter_checker.sv
`timescale 1ns / 100ps
// Checker for the gain, clip and power meter core: predicts every result from the
// sample and register beats it sees, and compares the results in order.
// Depends on gcop_pkg and the channel interfaces in gcop_if.sv.
module power_meter_checker (
  input  logic   clk,
  input  logic   rst,
  gcop_sample_if sample_mon,
  gcop_result_if result_mon,
  gcop_cfg_if    cfg_mon,
  output int     mismatches,
  output int     checked,
  output int     pending
);

  typedef struct {
    logic signed [gcop_pkg::SAMPLE_WIDTH-1:0] sample;
    logic [gcop_pkg::CH_W-1:0]                channel;
    logic [gcop_pkg::POWER_W-1:0]             power;
    logic                                     overload;
    logic                                     blk;
  } meter_result_t;

  logic [gcop_pkg::GAIN_W-1:0]   gain_q;
  logic [gcop_pkg::LIM_W-1:0]    clip_q;
  logic [gcop_pkg::SMOOTH_W-1:0] smooth_q;
  logic [gcop_pkg::POWER_W-1:0]  power_mem [gcop_pkg::CHANNELS];
  logic                          overload_mem [gcop_pkg::CHANNELS];

  meter_result_t expected_q[$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic meter_result_t predict_meter(
      input logic [gcop_pkg::CH_W-1:0] ch,
      input logic signed [gcop_pkg::SAMPLE_WIDTH-1:0] s,
      input logic clr, input logic blk);
    meter_result_t r;
    longint prod;
    longint y;
    longint lim;
    longint y2;
    longint diff;
    longint newp;
    logic   clipped;
    // Arithmetic shift of the signed product floors toward minus infinity.
    prod = longint'(s) * longint'(gain_q);
    y = prod >>> gcop_pkg::GAIN_FRAC;
    lim = longint'(clip_q);
    clipped = 1'b0;
    if (y > lim) begin
      y = lim;
      clipped = 1'b1;
    end
    if (y < -lim) begin
      y = -lim;
      clipped = 1'b1;
    end
    r.sample = y[gcop_pkg::SAMPLE_WIDTH-1:0];
    r.channel = ch;
    r.power = '0;
    r.overload = 1'b0;
    r.blk = blk;
    if (int'(ch) < gcop_pkg::CHANNELS) begin
      if (clr) overload_mem[ch] = 1'b0;
      if (clipped) overload_mem[ch] = 1'b1;
      // New power is y^2 plus the floored weighted difference to the old power.
      y2 = y * y;
      diff = longint'(power_mem[ch]) - y2;
      newp = y2 + ((longint'(smooth_q) * diff) >>> 16);
      power_mem[ch] = newp[gcop_pkg::POWER_W-1:0];
      r.power = power_mem[ch];
      r.overload = overload_mem[ch];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    meter_result_t want;
    if (rst) begin
      gain_q = gcop_pkg::GAIN_RESET;
      clip_q = gcop_pkg::CLIP_RESET;
      smooth_q = gcop_pkg::SMOOTH_RESET;
      for (int i = 0; i < gcop_pkg::CHANNELS; i++) begin
        power_mem[i] = '0;
        overload_mem[i] = 1'b0;
      end
      expected_q.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      // Results always trail their samples, so the result beat is checked first.
      if (result_mon.valid && result_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing expected, sample_out",
                          longint'(result_mon.sample_out), 0);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (result_mon.sample_out !== want.sample)
            report_mismatch("sample_out", longint'(result_mon.sample_out),
                            longint'(want.sample));
          if (result_mon.channel_out !== want.channel)
            report_mismatch("channel_out", longint'(result_mon.channel_out),
                            longint'(want.channel));
          if (result_mon.power_out !== want.power)
            report_mismatch("power_out", longint'(result_mon.power_out),
                            longint'(want.power));
          if (result_mon.overload_out !== want.overload)
            report_mismatch("overload_out", longint'(result_mon.overload_out),
                            longint'(want.overload));
          if (result_mon.block_end_out !== want.blk)
            report_mismatch("block_end_out", longint'(result_mon.block_end_out),
                            longint'(want.blk));
        end
      end
      if (sample_mon.valid && sample_mon.ready)
        expected_q.push_back(predict_meter(sample_mon.channel, sample_mon.sample_in,
                                           sample_mon.clear_overload,
                                           sample_mon.block_end));
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          gcop_pkg::CFG_GAIN:   gain_q = cfg_mon.data[gcop_pkg::GAIN_W-1:0];
          gcop_pkg::CFG_CLIP:   clip_q = cfg_mon.data[gcop_pkg::LIM_W-1:0];
          gcop_pkg::CFG_SMOOTH: smooth_q = cfg_mon.data[gcop_pkg::SMOOTH_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= expected_q.size();
  end

endmodule

// File: verif/tb_gain_clip_overload_power_meter_core.sv
`timescale 1ns / 100ps
// Top of the gain, clip and power meter testbench: clock, reset, sample and
// register stimulus, result back-pressure and the verdict.
// Depends on gcop_pkg, gcop_if.sv, the core RTL and power_meter_checker.
module tb_gain_clip_overload_power_meter_core;

  localparam logic [gcop_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 140;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 5000;

  logic clk;
  logic rst;

  gcop_sample_if sample_bus ();
  gcop_result_if result_bus ();
  gcop_cfg_if    cfg_bus ();

  int mismatches;
  int checked;
  int pending;
  int items_sent;
  int settings_used;
  int hold_cycles;
  bit tx_idle;
  bit rx_idle;

  gain_clip_overload_power_meter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_bus),
    .result_ch (result_bus),
    .cfg_ch    (cfg_bus)
  );

  power_meter_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .sample_mon (sample_bus),
    .result_mon (result_bus),
    .cfg_mon    (cfg_bus),
    .mismatches (mismatches),
    .checked    (checked),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still expected", pending);
    $display("Regression FAIL");
    $finish;
  end

  task automatic push_sample(input logic [gcop_pkg::CH_W-1:0] ch,
                             input logic signed [gcop_pkg::SAMPLE_WIDTH-1:0] s,
                             input logic clr, input logic blk);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid          <= 1'b1;
    sample_bus.channel        <= ch;
    sample_bus.sample_in      <= s;
    sample_bus.clear_overload <= clr;
    sample_bus.block_end      <= blk;
    do @(posedge clk); while (!sample_bus.ready);
    items_sent++;
  endtask

  task automatic push_random();
    logic signed [gcop_pkg::SAMPLE_WIDTH-1:0] s;
    case ($urandom_range(0, 9))
      0: s = 16'sh7FFF;
      1: s = 16'sh8000;
      2: s = 16'($urandom_range(0, 64) - 32);
      3: s = 16'($urandom_range(0, 4096) - 2048);
      default: s = 16'($urandom);
    endcase
    push_sample(gcop_pkg::CH_W'($urandom_range(0, 7)), s, $urandom_range(0, 7) == 0,
                $urandom_range(0, 15) == 0);
  endtask

  // Waits until every expected result is in, then lets the pipeline settle.
  task automatic drain_results();
    int guard;
    sample_bus.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gcop_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gcop_pkg::CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [gcop_pkg::CFG_DATA_W-1:0] g,
                           input logic [gcop_pkg::CFG_DATA_W-1:0] lim,
                           input logic [gcop_pkg::CFG_DATA_W-1:0] sm);
    write_reg(gcop_pkg::CFG_GAIN, g);
    write_reg(gcop_pkg::CFG_CLIP, lim);
    write_reg(gcop_pkg::CFG_SMOOTH, sm);
    write_reg(CFG_UNUSED, 16'($urandom));
    settings_used++;
  endtask

  // Result side: random stalls per beat if rx_idle, one long hold-off if requested.
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    result_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_cycles > 0 && !held) begin
        result_bus.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        held = 1'b1;
      end else begin
        gap = rx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
          result_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
    end
  end

  initial begin
    logic [gcop_pkg::CFG_DATA_W-1:0] g;
    logic [gcop_pkg::CFG_DATA_W-1:0] lim;
    logic [gcop_pkg::CFG_DATA_W-1:0] sm;
    rst                       <= 1'b1;
    sample_bus.valid          <= 1'b0;
    sample_bus.channel        <= '0;
    sample_bus.sample_in      <= '0;
    sample_bus.clear_overload <= 1'b0;
    sample_bus.block_end      <= 1'b0;
    cfg_bus.valid             <= 1'b0;
    cfg_bus.index             <= gcop_pkg::CFG_GAIN;
    cfg_bus.data              <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_cycles = 0;
    items_sent = 0;
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: unity gain, full-scale limit. The most negative input clamps.
    push_sample(3'd0, 16'sh7FFF, 1'b0, 1'b0);
    push_sample(3'd0, 16'sh8000, 1'b0, 1'b1);
    push_sample(3'd0, 16'sh0000, 1'b1, 1'b0);
    push_sample(3'd0, 16'sh8000, 1'b1, 1'b0);
    push_sample(3'd7, 16'shFFFF, 1'b0, 1'b1);
    push_sample(3'd7, 16'sh0001, 1'b1, 1'b0);
    push_sample(3'd5, 16'sh5555, 1'b0, 1'b0);
    push_sample(3'd2, 16'shAAAA, 1'b0, 1'b1);
    drain_results();

    // Maximum gain with a zero limit and no smoothing: every sample and power is zero.
    configure(16'hFFFF, 16'h0000, 16'h0000);
    push_sample(3'd2, 16'sh0000, 1'b0, 1'b0);
    push_sample(3'd2, 16'sh0001, 1'b0, 1'b0);
    push_sample(3'd3, 16'shFFFF, 1'b0, 1'b1);
    push_sample(3'd3, 16'sh7FFF, 1'b1, 1'b0);
    push_sample(3'd4, 16'sh8000, 1'b1, 1'b0);
    push_sample(3'd1, 16'sh0000, 1'b1, 1'b1);
    drain_results();

    // Zero gain, full smoothing: powers become floor(old * 65535 / 65536).
    configure(16'h0000, 16'h7FFF, 16'hFFFF);
    push_sample(3'd0, 16'sh7FFF, 1'b0, 1'b0);
    push_sample(3'd5, 16'sh8000, 1'b1, 1'b1);
    push_sample(3'd6, 16'sh1234, 1'b0, 1'b0);
    drain_results();

    // Moderate gain against a small limit, with the unused limit bit set.
    configure(16'h2000, 16'h8064, 16'h8000);
    push_sample(3'd6, 16'sh0031, 1'b0, 1'b0);
    push_sample(3'd6, 16'sh0033, 1'b0, 1'b0);
    push_sample(3'd6, 16'shFFCE, 1'b1, 1'b1);
    push_sample(3'd1, 16'shFFCD, 1'b1, 1'b0);
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0: g = 16'h0000;
        1: g = gcop_pkg::GAIN_RESET;
        2: g = 16'hFFFF;
        default: g = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: lim = 16'h0000;
        1: lim = 16'h7FFF;
        2: lim = 16'($urandom_range(1, 256));
        default: lim = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: sm = 16'h0000;
        1: sm = 16'hFFFF;
        2: sm = gcop_pkg::SMOOTH_RESET;
        default: sm = 16'($urandom);
      endcase
      configure(g, lim, sm);
      tx_idle = (phase % 4) != 1;
      rx_idle = (phase % 4) != 1;
      if (phase == 3) begin
        // The receiver stops for a long while samples are offered with no gaps.
        tx_idle = 1'b0;
        hold_cycles = 400;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) push_random();
      drain_results();
    end

    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Covered %0d sample beats under %0d register settings, %0d results compared",
             items_sent, settings_used, checked);
    $display("Included zero limit, zero and full gain and smoothing, and a long output stall");
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/gcop_pkg.sv
rtl/gcop_if.sv
rtl/gcop_cfg.sv
rtl/gcop_mul.sv
rtl/gain_clip_overload_power_meter_core.sv
verif/power_meter_checker.sv
verif/tb_gain_clip_overload_power_meter_core.sv
